FILE: rtl/s4tc_pkg.sv
`timescale 1ns / 1ps

package s4tc_pkg;

	// Fixed tile geometry
	localparam int TILE_BYTES    = 32;
	localparam int TILE_PIXELS   = 64;
	localparam int SURFACE_WIDTH = 128;
	localparam int SURFACE_SHIFT = $clog2(SURFACE_WIDTH);
	localparam int MAX_ROWS      = 16;
	localparam int ROWS_W        = 5;
	localparam int ADDR_W        = 14;
	localparam int DATA_W        = 8;
	localparam int POS_W         = 6;
	localparam int ROW_W         = 3;
	localparam int WORD_W        = 32;

	// Defaults for the top-level parameters
	localparam int DEF_TILE_LIMIT    = 256;
	localparam int DEF_TILES_PER_ROW = 16;

	localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(MAX_ROWS);

	typedef logic [1:0] action_t;

	localparam action_t ACT_DECODE  = 2'd0;
	localparam action_t ACT_ENCODE  = 2'd1;
	localparam action_t ACT_RESTART = 2'd2;

endpackage

FILE: rtl/s4tc_if.sv
`timescale 1ns / 1ps

interface s4tc_in_if import s4tc_pkg::*;;
	logic                valid;
	logic                ready;
	action_t             action;
	logic [DATA_W-1:0]   in_data;

	modport source (output valid, output action, output in_data, input ready);
	modport sink   (input valid, input action, input in_data, output ready);
endinterface

interface s4tc_out_if import s4tc_pkg::*;;
	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   out_data;
	logic [ADDR_W-1:0]   out_address;
	logic                last;

	modport source (output valid, output out_data, output out_address, output last,
		input ready);
	modport sink   (input valid, input out_data, input out_address, input last,
		output ready);
endinterface

FILE: rtl/snes_4bpp_planar_tile_codec_unit.sv
// Channel   Dir   Beat contents                        Accepted when
// item      in    action, in_data                      item.valid & item.ready
// result    out   out_data, out_address, last          result.valid & result.ready
// cfg       in    cfg_wdata (encode_tile_rows)         cfg_we
//
// For every byte or pixel beat, the accept cycle reads one row word of the tile memory
// and the next cycle writes it back modified. A dropped beat is accepted and discarded.
// A finished tile is read back row by row, each row word read before its beats, which go
// out one per cycle unless result stalls: 8 words, 64 beats decoded; 16 words, 32 encoded.
// Reset (arst_n low) clears counters and direction and sets rows to MAX_ROWS; tile memory is not reset.
// A stalled result holds the readout; new items wait until the readout is done.
`timescale 1ns / 1ps

module snes_4bpp_planar_tile_codec_unit import s4tc_pkg::*; #(
	parameter int TILE_LIMIT    = DEF_TILE_LIMIT,
	parameter int TILES_PER_ROW = DEF_TILES_PER_ROW
) (
	input  logic                clk,
	input  logic                arst_n,
	s4tc_in_if.sink             item,
	s4tc_out_if.source          result,
	input  logic                cfg_we,
	input  logic [ROWS_W-1:0]   cfg_wdata
);

	// Tile counter holds 0..TILE_LIMIT; tile column wraps at TILES_PER_ROW.
	localparam int TW  = $clog2(TILE_LIMIT + 1);
	localparam int TCW = (TILES_PER_ROW > 1) ? $clog2(TILES_PER_ROW) : 1;
	localparam int LW  = $clog2(TILES_PER_ROW * MAX_ROWS + TILE_LIMIT + 1);
	localparam int MEM_DEPTH = TILE_BYTES / 4;

	typedef enum logic [1:0] {ST_IDLE, ST_MOD, ST_RD, ST_OUT} state_t;

	state_t               state_q;
	logic [POS_W-1:0]     pos_q;
	logic [TW-1:0]        tile_q;
	logic [TCW-1:0]       tcol_q;
	logic [TW-1:0]        trow_q;
	logic                 dir_q;
	logic [ROWS_W-1:0]    rows_q;
	logic [POS_W-1:0]     k_q;
	logic                 em_enc_q;
	logic                 out_valid_q;
	logic [DATA_W-1:0]    out_data_q;
	logic [ADDR_W-1:0]    out_addr_q;
	logic                 out_last_q;

	// Accepted beat carried into the write-back cycle
	logic [DATA_W-1:0]    data_s1;
	logic [POS_W-1:0]     pos_s1;
	logic                 enc_s1;

	// Tile memory: one word per pixel row, lanes are planes 0..3
	logic [WORD_W-1:0]    mem [MEM_DEPTH];
	logic [WORD_W-1:0]    rd_q;
	logic [ROW_W-1:0]     raddr;
	logic [ROW_W-1:0]     waddr;
	logic [WORD_W-1:0]    wdata;
	logic                 we;

	logic                 want_enc;
	logic                 is_stream;
	logic                 dir_chg;
	logic [POS_W-1:0]     pos_e;
	logic [TW-1:0]        tile_e;
	logic                 rows_ok;
	logic [LW-1:0]        enc_prod;
	logic [LW-1:0]        enc_limit;
	logic                 take;
	logic                 mod_done;
	logic                 load;
	logic                 em_last;
	logic                 row_end;
	logic [2:0]           bsel;
	logic [1:0]           elane;
	logic [DATA_W-1:0]    em_data;
	logic [ADDR_W-1:0]    em_addr;

	assign item.ready         = (state_q == ST_IDLE);
	assign result.valid       = out_valid_q;
	assign result.out_data    = out_data_q;
	assign result.out_address = out_addr_q;
	assign result.last        = out_last_q;

	// Accept side: a change of direction drops the partial tile and the tile count.
	always_comb begin
		want_enc  = (item.action == ACT_ENCODE);
		is_stream = (item.action == ACT_DECODE) || (item.action == ACT_ENCODE);
		dir_chg   = is_stream && (want_enc != dir_q);
		pos_e     = dir_chg ? '0 : pos_q;
		tile_e    = dir_chg ? '0 : tile_q;

		// Encode tile budget: tiles per row times rows, capped at the tile limit; zero for an invalid row count
		rows_ok   = (rows_q != '0) && (rows_q <= ROWS_W'(MAX_ROWS));
		enc_prod  = LW'(TILES_PER_ROW) * LW'(rows_q);
		if (!rows_ok) begin
			enc_limit = '0;
		end else if (enc_prod > LW'(TILE_LIMIT)) begin
			enc_limit = LW'(TILE_LIMIT);
		end else begin
			enc_limit = enc_prod;
		end

		unique case (item.action)
			ACT_DECODE: take = (tile_e < TW'(TILE_LIMIT));
			ACT_ENCODE: take = (LW'(tile_e) < enc_limit);
			default:    take = 1'b0;
		endcase
	end

	// Read address: the beat's row while idle, else the readout row
	always_comb begin
		unique case (state_q)
			ST_IDLE: raddr = want_enc ? pos_e[5:3] : pos_e[3:1];
			default: raddr = em_enc_q ? k_q[3:1] : k_q[5:3];
		endcase
	end

	// Write-back: merge a byte into its plane lane, or set one bit in all four lanes.
	always_comb begin
		we       = (state_q == ST_MOD);
		waddr    = enc_s1 ? pos_s1[5:3] : pos_s1[3:1];
		wdata    = rd_q;
		mod_done = enc_s1 ? (pos_s1 == POS_W'(TILE_PIXELS - 1))
			: (pos_s1 == POS_W'(TILE_BYTES - 1));
		if (enc_s1) begin
			// first pixel of a row starts the row word fresh
			if (pos_s1[2:0] == 3'd0) begin
				wdata = '0;
			end
			for (int j = 0; j < 4; j++) begin
				wdata[{2'(j), ~pos_s1[2:0]}] = data_s1[j];
			end
		end else begin
			wdata[{pos_s1[4], pos_s1[0], 3'b000} +: DATA_W] = data_s1;
		end
	end

	// Readout: pixel from four plane bits (bit 7 leftmost), or one plane byte.
	always_comb begin
		bsel    = ~k_q[2:0];
		elane   = {k_q[4], k_q[0]};
		em_last = em_enc_q ? (k_q[4:0] == 5'(TILE_BYTES - 1))
			: (k_q == POS_W'(TILE_PIXELS - 1));
		row_end = em_enc_q ? k_q[0] : (k_q[2:0] == 3'd7);
		load    = (state_q == ST_OUT) && (!out_valid_q || result.ready);
		if (em_enc_q) begin
			em_data = rd_q[{elane, 3'b000} +: DATA_W];
			em_addr = ADDR_W'({tile_q, k_q[4:0]});
		end else begin
			em_data = {4'b0000, rd_q[{2'd3, bsel}], rd_q[{2'd2, bsel}],
				rd_q[{2'd1, bsel}], rd_q[{2'd0, bsel}]};
			em_addr = ADDR_W'({trow_q, k_q[5:3], SURFACE_SHIFT'(0)})
				+ ADDR_W'({tcol_q, k_q[2:0]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			tile_q      <= '0;
			tcol_q      <= '0;
			trow_q      <= '0;
			dir_q       <= 1'b0;
			rows_q      <= ROWS_RESET;
			k_q         <= '0;
			em_enc_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				rows_q <= cfg_wdata;
			end
			// drop the result once taken; a load below overrides
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						if (is_stream) begin
							dir_q <= want_enc;
						end
						if (dir_chg || (item.action == ACT_RESTART)) begin
							pos_q  <= '0;
							tile_q <= '0;
							tcol_q <= '0;
							trow_q <= '0;
						end
						if (take) begin
							state_q <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						pos_q    <= '0;
						k_q      <= '0;
						em_enc_q <= enc_s1;
						state_q  <= ST_RD;
					end else begin
						pos_q   <= pos_s1 + POS_W'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (load) begin
						out_valid_q <= 1'b1;
						if (em_last) begin
							// advance the tile position on the surface
							tile_q <= tile_q + TW'(1);
							if (tcol_q == TCW'(TILES_PER_ROW - 1)) begin
								tcol_q <= '0;
								trow_q <= trow_q + TW'(1);
							end else begin
								tcol_q <= tcol_q + TCW'(1);
							end
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + POS_W'(1);
							if (row_end) begin
								state_q <= ST_RD;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers and tile memory
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && item.valid) begin
			data_s1 <= item.in_data;
			pos_s1  <= pos_e;
			enc_s1  <= want_enc;
		end
		if (load) begin
			out_data_q <= em_data;
			out_addr_q <= em_addr;
			out_last_q <= em_last;
		end
		rd_q <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Decode never holds more than one tile's worth of bytes
	a_dec_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!dir_q |-> (pos_q < POS_W'(TILE_BYTES)))
		else $error("decode byte position out of range");

	a_tile_cap: assert property (@(posedge clk) disable iff (!arst_n)
		tile_q <= TW'(TILE_LIMIT))
		else $error("tile count beyond limit");

	// The closing beat of a tile always sits on the rightmost pixel or last byte
	a_last_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.last) |-> (result.out_address[2:0] == 3'd7))
		else $error("last beat at wrong address");

	a_out_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT) && ($past(state_q) != ST_OUT)) |-> ($past(state_q) == ST_RD))
		else $error("readout without row read");

	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		(we && mod_done) |=> (state_q == ST_RD))
		else $error("finished tile not read out");

endmodule
